/* hdl/mpsh_pkg.sv */
// Package with constants, types and the shared reduction step of the string hash block.
`timescale 1ns / 1ps

package mpsh_pkg;

  // Field widths.
  localparam int MOD_BITS  = 24;
  localparam int CHAR_BITS = 16;

  // Derived datapath widths.
  localparam int PROD_W    = CHAR_BITS + MOD_BITS;
  localparam int SUM_W     = PROD_W + 1;
  localparam int WT10_W    = MOD_BITS + 4;
  localparam int DIV_STEPS = (SUM_W + 1) / 2;
  localparam int DVD_W     = 2 * DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Base of the polynomial.
  localparam logic [3:0] WEIGHT_BASE = 4'd10;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic load_div;
    logic div_step;
    logic commit;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic size_zero;
    logic last;
    logic div_done;
  } sts_t;

  // One restoring step: shift in one dividend bit and subtract the modulus once.
  // The remainder is always below the modulus, so one compare is enough.
  function automatic logic [MOD_BITS-1:0] red_step(input logic [MOD_BITS-1:0] rem,
                                                    input logic                bit_in,
                                                    input logic [MOD_BITS-1:0] modulus);
    logic [MOD_BITS:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, modulus}) begin
      t = t - {1'b0, modulus};
    end
    return t[MOD_BITS-1:0];
  endfunction

endpackage

/* hdl/mpsh_if.sv */
// Channel interfaces of the string hash block: input, result and configuration.
`timescale 1ns / 1ps

interface mpsh_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpsh_pkg::CHAR_BITS-1:0] char_code;
  logic                          last_char;
  logic                          empty_key;

  modport source (output valid, output char_code, output last_char, output empty_key,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input empty_key,
                output ready);
endinterface

interface mpsh_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpsh_pkg::MOD_BITS-1:0] bucket_index;
  logic                         size_error;

  modport source (output valid, output bucket_index, output size_error, input ready);
  modport sink (input valid, input bucket_index, input size_error, output ready);
endinterface

interface mpsh_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mpsh_pkg::MOD_BITS-1:0] hash_size;

  modport source (output valid, output hash_size, input ready);
  modport sink (input valid, input hash_size, output ready);
endinterface

/* hdl/mpsh_ctrl.sv */
// Controller state machine that sequences one character through multiply and reduction.
`timescale 1ns / 1ps

module mpsh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_char,
  input  logic            in_empty_key,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  mpsh_pkg::sts_t  sts,
  output mpsh_pkg::cmd_t  cmd
);

  mpsh_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == mpsh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      mpsh_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_empty_key) begin
            state_nxt = mpsh_pkg::ST_EMIT;
          end else if (sts.size_zero) begin
            state_nxt = in_last_char ? mpsh_pkg::ST_EMIT : mpsh_pkg::ST_IDLE;
          end else begin
            state_nxt = mpsh_pkg::ST_MUL;
          end
        end
      end
      mpsh_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mpsh_pkg::ST_LOAD;
      end
      mpsh_pkg::ST_LOAD: begin
        cmd.load_div = 1'b1;
        state_nxt    = mpsh_pkg::ST_DIV;
      end
      mpsh_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = mpsh_pkg::ST_FIN;
        end
      end
      mpsh_pkg::ST_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.last ? mpsh_pkg::ST_EMIT : mpsh_pkg::ST_IDLE;
      end
      mpsh_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = mpsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpsh_pkg::ST_IDLE;
      end
    endcase
  end

  // The output word stays valid until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpsh_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/mpsh_dp.sv */
// Datapath: size register, hash state, multiplier, two-bit-per-cycle modulo reducer, result.
`timescale 1ns / 1ps

module mpsh_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpsh_pkg::cmd_t                cmd,
  output mpsh_pkg::sts_t                sts,
  input  logic                          cfg_write,
  input  logic [mpsh_pkg::MOD_BITS-1:0] cfg_hash_size,
  input  logic [mpsh_pkg::CHAR_BITS-1:0] in_char_code,
  input  logic                          in_last_char,
  input  logic                          in_empty_key,
  output logic [mpsh_pkg::MOD_BITS-1:0] out_bucket_index,
  output logic                          out_size_error
);

  logic [mpsh_pkg::MOD_BITS-1:0]  hash_size_r;
  logic [mpsh_pkg::MOD_BITS-1:0]  hash_r, hash_nxt;
  logic [mpsh_pkg::MOD_BITS-1:0]  weight_r, weight_nxt;
  logic                           neg_r, neg_nxt;
  logic                           kerr_r, kerr_nxt;
  logic                           last_r;
  logic                           empty_r;
  logic [mpsh_pkg::CHAR_BITS-1:0] char_r;
  logic [mpsh_pkg::PROD_W-1:0]    prod_r;
  logic [mpsh_pkg::DVD_W-1:0]     dvd_h_r, dvd_w_r;
  logic [mpsh_pkg::MOD_BITS-1:0]  rem_h_r, rem_w_r;
  logic [mpsh_pkg::CNT_W-1:0]     cnt_r;
  logic                           upd_r;
  logic                           size_zero;
  logic [mpsh_pkg::SUM_W-1:0]     sum_h;
  logic [mpsh_pkg::WT10_W-1:0]    wt10;
  logic [mpsh_pkg::MOD_BITS-1:0]  bucket_nxt;
  logic                           err_nxt;

  assign size_zero     = (hash_size_r == '0);
  assign sts.size_zero = size_zero;
  assign sts.last      = last_r;
  assign sts.div_done  = (cnt_r == mpsh_pkg::CNT_W'(mpsh_pkg::DIV_STEPS - 1));

  // Size register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_size_r <= '0;
    end else if (cfg_write) begin
      hash_size_r <= cfg_hash_size;
    end
  end

  // Input word capture and product.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      char_r  <= in_char_code;
      last_r  <= in_last_char;
      empty_r <= in_empty_key;
    end
    if (cmd.mul) begin
      prod_r <= mpsh_pkg::PROD_W'(char_r) * mpsh_pkg::PROD_W'(weight_r);
    end
  end

  // Dividends: the new hash before reduction and the weight times the base.
  // While the hash still holds minus one it becomes product minus one.
  always_comb begin
    if (neg_r) begin
      sum_h = (prod_r == '0) ? '0 : mpsh_pkg::SUM_W'(prod_r) - mpsh_pkg::SUM_W'(1);
    end else begin
      sum_h = mpsh_pkg::SUM_W'(hash_r) + mpsh_pkg::SUM_W'(prod_r);
    end
    wt10 = mpsh_pkg::WT10_W'(weight_r) * mpsh_pkg::WT10_W'(mpsh_pkg::WEIGHT_BASE);
  end

  // Reducer: two restoring steps per cycle on both dividends at once.
  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      dvd_h_r <= mpsh_pkg::DVD_W'(sum_h);
      dvd_w_r <= mpsh_pkg::DVD_W'(wt10);
      rem_h_r <= '0;
      rem_w_r <= '0;
      cnt_r   <= '0;
      upd_r   <= !neg_r || (prod_r != '0) || (hash_size_r == mpsh_pkg::MOD_BITS'(1));
    end else if (cmd.div_step) begin
      rem_h_r <= mpsh_pkg::red_step(
                   mpsh_pkg::red_step(rem_h_r, dvd_h_r[mpsh_pkg::DVD_W-1], hash_size_r),
                   dvd_h_r[mpsh_pkg::DVD_W-2], hash_size_r);
      rem_w_r <= mpsh_pkg::red_step(
                   mpsh_pkg::red_step(rem_w_r, dvd_w_r[mpsh_pkg::DVD_W-1], hash_size_r),
                   dvd_w_r[mpsh_pkg::DVD_W-2], hash_size_r);
      dvd_h_r <= {dvd_h_r[mpsh_pkg::DVD_W-3:0], 2'b00};
      dvd_w_r <= {dvd_w_r[mpsh_pkg::DVD_W-3:0], 2'b00};
      cnt_r   <= cnt_r + mpsh_pkg::CNT_W'(1);
    end
  end

  // Hash state update; an emitted result returns it to the start of a key.
  always_comb begin
    hash_nxt   = hash_r;
    weight_nxt = weight_r;
    neg_nxt    = neg_r;
    kerr_nxt   = kerr_r;
    if (cmd.emit) begin
      hash_nxt   = '0;
      weight_nxt = mpsh_pkg::MOD_BITS'(1);
      neg_nxt    = 1'b1;
      kerr_nxt   = 1'b0;
    end else if (cmd.commit) begin
      weight_nxt = (rem_w_r == '0) ? mpsh_pkg::MOD_BITS'(1) : rem_w_r;
      if (upd_r) begin
        hash_nxt = rem_h_r;
        neg_nxt  = 1'b0;
      end
    end else if (cmd.load_in && !in_empty_key && size_zero) begin
      kerr_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      weight_r <= mpsh_pkg::MOD_BITS'(1);
      neg_r    <= 1'b1;
      kerr_r   <= 1'b0;
    end else begin
      hash_r   <= hash_nxt;
      weight_r <= weight_nxt;
      neg_r    <= neg_nxt;
      kerr_r   <= kerr_nxt;
    end
  end

  // Result word.
  always_comb begin
    if (empty_r) begin
      err_nxt    = size_zero;
      bucket_nxt = size_zero ? '0 : mpsh_pkg::MOD_BITS'(1);
    end else begin
      err_nxt    = kerr_r;
      bucket_nxt = kerr_r ? '0 : (neg_r ? mpsh_pkg::MOD_BITS'(1) : hash_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bucket_index <= bucket_nxt;
      out_size_error   <= err_nxt;
    end
  end

endmodule

/* hdl/modular_polynomial_string_hash.sv */
// Top level of the polynomial string hash: channels, controller, datapath and checks.
`timescale 1ns / 1ps

// Hashes a key, one character per input word, into a bucket index modulo hash_size.
// in_ch carries char_code, last_char and empty_key; a result word on out_ch follows
// the character marked last, or an empty-key word at once. cfg_ch writes hash_size
// and is always ready; write it only while no key is in flight.
// Per character with a nonzero size the steps are: accept, one multiply, one load, the
// reducer that retires two dividend bits per cycle on the 41-bit hash sum and the weight
// in parallel, and a commit. No new character is accepted until that character has
// been committed. The last character of a key adds an emit step. A character taken
// while hash_size is zero only takes the accept step; an empty key, or a last character
// while hash_size is zero, takes accept and emit.
// The result word is loaded in the emit step that follows the last character's commit,
// or the accept of an empty key. A new character is accepted while that word waits; if
// the receiver still stalls when the next result is ready, the block holds in its emit
// step and takes no input until the word leaves.
// Reset clears hash_size to zero, the hash state to its start values and drops
// any pending result.
module modular_polynomial_string_hash (
  input logic      clk,
  input logic      rst_n,
  mpsh_in_if.sink  in_ch,
  mpsh_out_if.source out_ch,
  mpsh_cfg_if.sink cfg_ch
);

  mpsh_pkg::cmd_t cmd;
  mpsh_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  mpsh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_last_char (in_ch.last_char),
    .in_empty_key (in_ch.empty_key),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  mpsh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write        (cfg_ch.valid),
    .cfg_hash_size    (cfg_ch.hash_size),
    .in_char_code     (in_ch.char_code),
    .in_last_char     (in_ch.last_char),
    .in_empty_key     (in_ch.empty_key),
    .out_bucket_index (out_ch.bucket_index),
    .out_size_error   (out_ch.size_error)
  );

  // A result loaded into the output register is presented on the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

  // An error result always carries a zero index.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.size_error |-> out_ch.bucket_index == '0)
    else $error("size error with nonzero index");

  // The reducer never runs with a zero modulus.
  a_div_size: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !sts.size_zero)
    else $error("reduction with zero modulus");

  // Input is taken only when no result is being loaded in the same cycle.
  a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |-> !cmd.emit && !cmd.commit)
    else $error("input accepted during commit or emit");

endmodule

/* test/testbench.sv */
// Self-checking testbench of the polynomial string hash block, with its own bucket predictor.
`timescale 1ns / 1ps

module testbench;
  import mpsh_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 3;
  // Processing time of one character with a nonzero size inside the block.
  localparam int CHAR_CYCLES   = 25;
  localparam int SETTLE_CYCLES = CHAR_CYCLES + 10;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int IDLE_PCT      = 29;
  localparam int RAND_PHASES   = 30;
  localparam int PHASE_WORDS   = 54;
  localparam int QUIET_FIRST   = 12;
  localparam int QUIET_LAST    = 15;
  localparam int HOLD_PHASE    = 5;
  localparam int HOLD_CYCLES   = 600;
  localparam int DIRECTED_ROWS = 31;

  typedef enum bit {ROW_WRITE_SIZE, ROW_WORD} row_kind_t;

  // One directed row: either a table size write or one input word.
  typedef struct packed {
    row_kind_t             kind;
    logic [MOD_BITS-1:0]   value;
    logic                  last;
    logic                  empty;
    logic                  typed;
    logic [MOD_BITS-1:0]   exp_index;
    logic                  exp_error;
  } stim_row_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] bucket_index;
    logic                size_error;
  } bucket_word_t;

  logic clk;
  logic rst_n;

  mpsh_in_if  in_ch ();
  mpsh_out_if out_ch ();
  mpsh_cfg_if cfg_ch ();

  modular_polynomial_string_hash dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: the table size and the hash of the key in progress.
  logic [MOD_BITS-1:0] table_size;
  logic [MOD_BITS-1:0] hash_acc;
  logic [MOD_BITS-1:0] hash_weight;
  bit                  hash_neg;
  bit                  key_err;

  bucket_word_t bucket_expect[$];

  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // Directed rows. An expected word is typed in only where it is obvious; the rest
  // come from the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Size zero after reset: an empty key and a one-character key both flag the error.
    '{ROW_WORD,       'h41,     1'b0, 1'b1, 1'b1, 'd0,     1'b1},
    '{ROW_WORD,       'h41,     1'b1, 1'b0, 1'b1, 'd0,     1'b1},
    // Size one: an empty key still gives 1, a zero character turns minus one into 0.
    '{ROW_WRITE_SIZE, 'd1,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'hBEEF,   1'b0, 1'b1, 1'b1, 'd1,     1'b0},
    '{ROW_WORD,       'h0,      1'b1, 1'b0, 1'b1, 'd0,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b1, 1'b0, 1'b1, 'd0,     1'b0},
    // Largest size: the largest character, and a zero character that keeps minus one.
    '{ROW_WRITE_SIZE, 'hFFFFFF, 1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b1, 1'b0, 1'b1, 'd65534, 1'b0},
    '{ROW_WORD,       'h0,      1'b1, 1'b0, 1'b1, 'd1,     1'b0},
    '{ROW_WORD,       'h0,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h1234,   1'b1, 1'b0, 1'b0, 'd0,     1'b0},
    // An empty key in the middle of a key drops the partial key.
    '{ROW_WORD,       'h7,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h5555,   1'b1, 1'b1, 1'b1, 'd1,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'hFFFF,   1'b1, 1'b0, 1'b0, 'd0,     1'b0},
    // The size changes between two characters of one key.
    '{ROW_WORD,       'h61,     1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WRITE_SIZE, 'd97,     1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h62,     1'b1, 1'b0, 1'b0, 'd0,     1'b0},
    // The size drops to zero inside a key, so the key reports the error.
    '{ROW_WORD,       'h63,     1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WRITE_SIZE, 'd0,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h64,     1'b1, 1'b0, 1'b1, 'd0,     1'b1},
    // Size ten: the weight wraps to zero and is replaced by one.
    '{ROW_WRITE_SIZE, 'd10,     1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h3,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h4,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h5,      1'b1, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WRITE_SIZE, 'd2,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h1,      1'b0, 1'b0, 1'b0, 'd0,     1'b0},
    '{ROW_WORD,       'h1,      1'b1, 1'b0, 1'b0, 'd0,     1'b0}
  };

  // Clock generation.
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Returns the hash state to the start of a key.
  function automatic void restart_key();
    hash_acc    = '0;
    hash_weight = MOD_BITS'(1);
    hash_neg    = 1'b1;
    key_err     = 1'b0;
  endfunction

  // Advances the predicted hash by one input word; returns 1 when a bucket word results.
  function automatic bit predict_bucket(input logic [CHAR_BITS-1:0] ch, input bit last,
                                        input bit empty, output bucket_word_t word);
    longint unsigned m;
    longint unsigned prod;
    longint unsigned nxt;
    m = 64'(table_size);
    word = '0;
    if (empty) begin
      restart_key();
      word.size_error   = (m == 0);
      word.bucket_index = (m == 0) ? '0 : MOD_BITS'(1);
      return 1'b1;
    end
    if (m == 0) begin
      key_err = 1'b1;
    end else begin
      prod = 64'(ch);
      prod = prod * 64'(hash_weight);
      // While the hash is still minus one, adding the product is a subtraction of one.
      if (hash_neg) begin
        if (prod != 0) begin
          nxt = (prod - 1) % m;
          hash_acc = nxt[MOD_BITS-1:0];
          hash_neg = 1'b0;
        end else if (m == 1) begin
          hash_acc = '0;
          hash_neg = 1'b0;
        end
      end else begin
        nxt = 64'(hash_acc);
        nxt = (nxt + prod) % m;
        hash_acc = nxt[MOD_BITS-1:0];
      end
      nxt = 64'(hash_weight);
      nxt = (nxt * 64'(WEIGHT_BASE)) % m;
      if (nxt == 0) begin
        nxt = 64'd1;
      end
      hash_weight = nxt[MOD_BITS-1:0];
    end
    if (last) begin
      word.size_error   = key_err;
      word.bucket_index = key_err ? '0 : (hash_neg ? MOD_BITS'(1) : hash_acc);
      restart_key();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drops the input valid, waits for every expected word and lets a character finish.
  task automatic wait_block_idle();
    in_ch.valid <= 1'b0;
    while (bucket_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the table size while the block is idle.
  task automatic write_size(input logic [MOD_BITS-1:0] size);
    wait_block_idle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.hash_size <= size;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    table_size = size;
  endtask

  // Offers one input word, after a random idle gap, and records the expected bucket word.
  task automatic send_word(input logic [CHAR_BITS-1:0] ch, input bit last, input bit empty,
                           input bit typed, input bucket_word_t typed_word);
    bucket_word_t word;
    bit           has_word;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= ch;
    in_ch.last_char <= last;
    in_ch.empty_key <= empty;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    has_word = predict_bucket(ch, last, empty, word);
    if (has_word) begin
      bucket_expect.push_back(typed ? typed_word : word);
    end
  endtask

  // Sends one random key: mostly well-formed, some empty keys and some keys cut short.
  task automatic send_key(output int n_words);
    int                   len;
    int                   r;
    bit                   cut;
    logic [CHAR_BITS-1:0] ch;
    r = $urandom_range(99);
    if (r < 7) begin
      send_word(CHAR_BITS'($urandom), 1'($urandom_range(1)), 1'b1, 1'b0, '0);
      n_words = 1;
    end else begin
      len = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
      cut = (r < 11);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(9))
          0: ch = '0;
          1: ch = '1;
          2, 3, 4, 5: ch = CHAR_BITS'($urandom_range(32, 126));
          default: ch = CHAR_BITS'($urandom);
        endcase
        send_word(ch, (i == len - 1) && !cut, 1'b0, 1'b0, '0);
      end
      n_words = len;
      // A key cut short ends in an empty key instead of its last character.
      if (cut) begin
        send_word(CHAR_BITS'($urandom), 1'($urandom_range(1)), 1'b1, 1'b0, '0);
        n_words = len + 1;
      end
    end
  endtask

  // Result side: checks each accepted word and drives ready with random stalls.
  always @(posedge clk) begin : result_sink
    bucket_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (bucket_expect.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected bucket word: expected none, got index %0d error %0b",
                 $time, out_ch.bucket_index, out_ch.size_error);
      end else begin
        want = bucket_expect.pop_front();
        if (out_ch.bucket_index !== want.bucket_index ||
            out_ch.size_error !== want.size_error) begin
          mismatch_count++;
          $display("%0t: bucket word mismatch: expected index %0d error %0b,",
                   $time, want.bucket_index, want.size_error,
                   " got index %0d error %0b", out_ch.bucket_index, out_ch.size_error);
        end
      end
    end
    // A long hold-off is counted here once the stimulus asks for it.
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then random phases with changing sizes.
  initial begin : stimulus
    int                  n_words;
    int                  sent;
    logic [MOD_BITS-1:0] size;
    bucket_word_t        typed_word;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.last_char  = 1'b0;
    in_ch.empty_key  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.hash_size = '0;
    table_size       = '0;
    restart_key();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE_SIZE) begin
        write_size(directed_rows[i].value);
      end else begin
        typed_word.bucket_index = directed_rows[i].exp_index;
        typed_word.size_error   = directed_rows[i].exp_error;
        send_word(directed_rows[i].value[CHAR_BITS-1:0], directed_rows[i].last,
                  directed_rows[i].empty, directed_rows[i].typed, typed_word);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase % 10)
        0: size = '1;
        1: size = MOD_BITS'($urandom_range(1, 16));
        2: size = MOD_BITS'($urandom_range(17, 1000));
        3: size = MOD_BITS'($urandom_range(1001, 24'hFFFFFF));
        4: size = (phase == 4) ? '0 : MOD_BITS'(1);
        5: size = MOD_BITS'(10);
        6: size = MOD_BITS'($urandom_range(24'h100000, 24'hFFFFFF));
        7: size = MOD_BITS'(2);
        default: size = MOD_BITS'($urandom);
      endcase
      // Each phase starts only after every expected word of the last one has come.
      write_size(size);
      if (phase >= QUIET_FIRST && phase <= QUIET_LAST) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
      end
      // The receiver holds off long enough for the block to back up into its input.
      if (phase == HOLD_PHASE) begin
        hold_requests++;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        send_key(n_words);
        sent += n_words;
      end
    end

    wait_block_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
